// ===== design/servo_status_packet_parser_macros.svh =====
// Assertion macros used by the checker file of the servo status packet parser.
`ifndef SERVO_STATUS_PACKET_PARSER_MACROS_SVH
`define SERVO_STATUS_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSPP_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define SSPP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

// ===== design/sspp_pkg.sv =====
// Types and constants shared by the servo status packet parser modules.
package sspp_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [7:0] LEN_OVERHEAD   = 8'd2;
    localparam logic [7:0] EXPECTED_ID_RST = 8'd1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_ID     = 3'd1,
        PH_LEN    = 3'd2,
        PH_STATUS = 3'd3,
        PH_PARAM  = 3'd4,
        PH_CHECK  = 3'd5
    } t_phase;

    typedef enum logic {
        KIND_PARAM   = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        VERD_OK       = 2'd0,
        VERD_WRONG_ID = 2'd1,
        VERD_CHECKSUM = 2'd2,
        VERD_STATUS   = 2'd3
    } t_verdict;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] param_byte;
        logic [7:0] param_index;
        t_verdict   verdict;
        logic [7:0] status_byte;
        logic [7:0] packet_length;
    } t_result;

endpackage

// ===== design/servo_status_packet_parser.sv =====
// Top level of the servo status packet parser.
// The parser takes one received word per clock, unless o_in_stall holds it, and hunts
// for two 0xFF sync words, then checks the id, takes length and status, emits each
// parameter word with its index, and closes the packet with a verdict word (ok, wrong
// id, checksum error, status error). Each result is registered in the output buffer;
// one result register plus one skid entry sit behind a framing state machine, so the
// input is stalled only while both hold results.
module servo_status_packet_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_param_byte,
    output logic [7:0] o_param_index,
    output logic [1:0] o_verdict,
    output logic [7:0] o_status_byte,
    output logic [7:0] o_packet_length
);
    import sspp_pkg::*;

    logic    in_accept;
    logic    has_result;
    logic    buf_full;
    t_result core_result;
    t_result out_result;

    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    sspp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_byte       (i_rx_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    sspp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (has_result),
        .i_data  (core_result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_full  (buf_full),
        .o_data  (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_param_byte    = out_result.param_byte;
    assign o_param_index   = out_result.param_index;
    assign o_verdict       = out_result.verdict;
    assign o_status_byte   = out_result.status_byte;
    assign o_packet_length = out_result.packet_length;

endmodule

// ===== design/sspp_core.sv =====
// Packet framing state machine that turns one received word into at most one result.
module sspp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    output logic             o_has_result,
    output sspp_pkg::t_result o_result
);
    import sspp_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_last_sync, n_last_sync;
    logic [7:0] r_length, n_length;
    logic [7:0] r_status, n_status;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_left, n_left;
    logic [7:0] r_expected_id;
    logic [7:0] param_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_last_sync   <= 1'b0;
            r_length      <= '0;
            r_status      <= '0;
            r_sum         <= '0;
            r_left        <= '0;
            r_expected_id <= EXPECTED_ID_RST;
        end else begin
            r_phase     <= n_phase;
            r_last_sync <= n_last_sync;
            r_length    <= n_length;
            r_status    <= n_status;
            r_sum       <= n_sum;
            r_left      <= n_left;
            if (i_cfg_we) begin
                r_expected_id <= i_cfg_data;
            end
        end
    end

    assign param_count = (r_length > LEN_OVERHEAD) ? (r_length - LEN_OVERHEAD) : '0;

    always_comb begin
        n_phase      = r_phase;
        n_last_sync  = r_last_sync;
        n_length     = r_length;
        n_status     = r_status;
        n_sum        = r_sum;
        n_left       = r_left;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_accept) begin
            case (r_phase)
                PH_ID: begin
                    if (i_byte != r_expected_id) begin
                        o_has_result     = 1'b1;
                        o_result.kind    = KIND_VERDICT;
                        o_result.verdict = VERD_WRONG_ID;
                        n_phase          = PH_HUNT;
                        n_last_sync      = 1'b0;
                    end else begin
                        n_sum   = i_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_length = i_byte;
                    n_sum    = r_sum + i_byte;
                    n_left   = (i_byte > LEN_OVERHEAD) ? (i_byte - LEN_OVERHEAD) : '0;
                    n_phase  = PH_STATUS;
                end
                PH_STATUS: begin
                    n_status = i_byte;
                    n_sum    = r_sum + i_byte;
                    n_phase  = (r_left != '0) ? PH_PARAM : PH_CHECK;
                end
                PH_PARAM: begin
                    o_has_result           = 1'b1;
                    o_result.kind          = KIND_PARAM;
                    o_result.param_byte    = i_byte;
                    o_result.param_index   = param_count - r_left;
                    o_result.verdict       = VERD_OK;
                    o_result.status_byte   = r_status;
                    o_result.packet_length = r_length;
                    n_sum                  = r_sum + i_byte;
                    n_left                 = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_has_result           = 1'b1;
                    o_result.kind          = KIND_VERDICT;
                    o_result.status_byte   = r_status;
                    o_result.packet_length = r_length;
                    if (~r_sum != i_byte) begin
                        o_result.verdict = VERD_CHECKSUM;
                    end else if (r_status != '0) begin
                        o_result.verdict = VERD_STATUS;
                    end else begin
                        o_result.verdict = VERD_OK;
                    end
                    n_phase     = PH_HUNT;
                    n_last_sync = 1'b0;
                end
                default: begin
                    n_phase     = PH_HUNT;
                    n_last_sync = 1'b0;
                    if (i_byte == SYNC_BYTE) begin
                        if (r_last_sync) begin
                            n_phase = PH_ID;
                        end else begin
                            n_last_sync = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/sspp_out_buf.sv =====
// Output register with a skid entry so input words keep flowing while a result waits.
module sspp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sspp_pkg::t_result i_data,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_full,
    output sspp_pkg::t_result o_data
);
    import sspp_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_full  = r_skid_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_data;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// ===== design/sspp_checker.sv =====
// Port-level checker for the servo status packet parser and its bind statement.
`include "servo_status_packet_parser_macros.svh"

module sspp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [7:0] i_cfg_data,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_kind,
    input logic [7:0] o_param_byte,
    input logic [7:0] o_param_index,
    input logic [1:0] o_verdict,
    input logic [7:0] o_status_byte,
    input logic [7:0] o_packet_length
);
    import sspp_pkg::*;

    `SSPP_ASSERT_NEXT(a_stalled_word_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_param_byte) && $stable(o_param_index) && $stable(o_verdict) && $stable(o_status_byte) && $stable(o_packet_length))
    `SSPP_ASSERT_SAME(a_wrong_id_clean, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_VERDICT) && (o_verdict == VERD_WRONG_ID), (o_status_byte == 8'd0) && (o_packet_length == 8'd0))
    `SSPP_ASSERT_SAME(a_param_in_range, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_PARAM), (o_verdict == VERD_OK) && (o_packet_length > LEN_OVERHEAD) && (o_param_index < (o_packet_length - LEN_OVERHEAD)))
    `SSPP_ASSERT_SAME(a_verdict_no_param, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_VERDICT), (o_param_byte == 8'd0) && (o_param_index == 8'd0))

endmodule

bind servo_status_packet_parser sspp_checker u_sspp_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the servo status packet parser: directed, config and random words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sspp_pkg::*;

    localparam int STALL_LIMIT    = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_WORDS   = 200;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_kind;
    logic [7:0] o_param_byte;
    logic [7:0] o_param_index;
    logic [1:0] o_verdict;
    logic [7:0] o_status_byte;
    logic [7:0] o_packet_length;

    t_result    pending_words[$];
    t_phase     ph;
    bit         sync_seen;
    logic [7:0] id_reg;
    logic [7:0] len_seen;
    logic [7:0] stat_seen;
    logic [7:0] sum_acc;
    logic [7:0] params_left;

    int errors;
    int words_sent;
    int idle_count;
    int holdoff_req;
    bit tx_gaps_on;
    bit rx_stalls_on;

    servo_status_packet_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_param_byte   (o_param_byte),
        .o_param_index  (o_param_index),
        .o_verdict      (o_verdict),
        .o_status_byte  (o_status_byte),
        .o_packet_length(o_packet_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void parse_rx_byte(input logic [7:0] b);
        t_result  r;
        t_verdict v;
        logic [7:0] count;
        r = '0;
        case (ph)
            PH_ID: begin
                if (b != id_reg) begin
                    r.kind    = KIND_VERDICT;
                    r.verdict = VERD_WRONG_ID;
                    pending_words.push_back(r);
                    ph        = PH_HUNT;
                    sync_seen = 1'b0;
                end else begin
                    sum_acc = b;
                    ph      = PH_LEN;
                end
            end
            PH_LEN: begin
                len_seen    = b;
                sum_acc     = sum_acc + b;
                params_left = (b > LEN_OVERHEAD) ? 8'(b - LEN_OVERHEAD) : 8'd0;
                ph          = PH_STATUS;
            end
            PH_STATUS: begin
                stat_seen = b;
                sum_acc   = sum_acc + b;
                ph        = (params_left != 8'd0) ? PH_PARAM : PH_CHECK;
            end
            PH_PARAM: begin
                count           = 8'(len_seen - LEN_OVERHEAD);
                r.kind          = KIND_PARAM;
                r.param_byte    = b;
                r.param_index   = 8'(count - params_left);
                r.verdict       = VERD_OK;
                r.status_byte   = stat_seen;
                r.packet_length = len_seen;
                pending_words.push_back(r);
                sum_acc     = sum_acc + b;
                params_left = params_left - 8'd1;
                if (params_left == 8'd0) begin
                    ph = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (b != 8'(~sum_acc)) begin
                    v = VERD_CHECKSUM;
                end else if (stat_seen != 8'd0) begin
                    v = VERD_STATUS;
                end else begin
                    v = VERD_OK;
                end
                r.kind          = KIND_VERDICT;
                r.verdict       = v;
                r.status_byte   = stat_seen;
                r.packet_length = len_seen;
                pending_words.push_back(r);
                ph        = PH_HUNT;
                sync_seen = 1'b0;
            end
            default: begin
                if (b == SYNC_BYTE && sync_seen) begin
                    ph        = PH_ID;
                    sync_seen = 1'b0;
                end else begin
                    ph        = PH_HUNT;
                    sync_seen = (b == SYNC_BYTE);
                end
            end
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none actual kind %0h byte %0h verdict %0h",
                         $time, o_kind, o_param_byte, o_verdict);
                errors++;
            end else begin
                want = pending_words.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("param_byte", want.param_byte, o_param_byte);
                check_field("param_index", want.param_index, o_param_index);
                check_field("verdict", want.verdict, o_verdict);
                check_field("status_byte", want.status_byte, o_status_byte);
                check_field("packet_length", want.packet_length, o_packet_length);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req != 0) begin
                i_out_stall <= 1'b1;
                repeat (holdoff_req) @(negedge i_clk);
                holdoff_req = 0;
                i_out_stall <= 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic [7:0] b);
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        parse_rx_byte(b);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_expected_id(input logic [7:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        id_reg = v;
    endtask

    // A negative fill gives random parameter words; keep cuts the packet short.
    task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                               input logic [7:0] status, input int fill,
                               input bit bad_sum, input int keep);
        logic [7:0] pkt[$];
        logic [7:0] sum;
        logic [7:0] p;
        int n;
        pkt = {SYNC_BYTE, SYNC_BYTE, id, len, status};
        sum = id + len + status;
        n = (len > LEN_OVERHEAD) ? int'(len - LEN_OVERHEAD) : 0;
        for (int k = 0; k < n; k++) begin
            p = (fill < 0) ? 8'($urandom) : 8'(fill);
            pkt.push_back(p);
            sum = sum + p;
        end
        pkt.push_back(bad_sum ? 8'(~sum ^ 8'($urandom_range(1, 255))) : 8'(~sum));
        if (keep < 0 || keep > pkt.size()) begin
            keep = pkt.size();
        end
        for (int k = 0; k < keep; k++) begin
            send_word(pkt[k]);
        end
    endtask

    task automatic send_random_packet();
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] status;
        int pick;
        int keep;
        id   = ($urandom_range(0, 9) != 0) ? id_reg : 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = 8'($urandom_range(0, 8));
        end else if (pick < 98) begin
            len = 8'($urandom_range(9, 40));
        end else begin
            len = 8'($urandom_range(41, 255));
        end
        status = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
        keep   = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 6)) : -1;
        send_packet(id, len, status, -1, $urandom_range(0, 6) == 0, keep);
    endtask

    task automatic send_noise(input int n);
        repeat (n) begin
            send_word(($urandom_range(0, 9) < 3) ? SYNC_BYTE : 8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_packet(EXPECTED_ID_RST, 8'd2, 8'h00, -1, 1'b0, -1);
        // A third sync word is taken as the id and rejected.
        send_word(SYNC_BYTE);
        send_word(SYNC_BYTE);
        send_word(SYNC_BYTE);
        send_packet(EXPECTED_ID_RST, 8'd0, 8'h80, -1, 1'b1, -1);
        send_packet(EXPECTED_ID_RST, 8'd3, 8'h01, 8'hFF, 1'b0, -1);
        send_word(8'h00);
        send_word(SYNC_BYTE);
        send_word(8'h00);
        wait_idle();
    endtask

    task automatic test_id_settings();
        logic [7:0] ids[5];
        ids = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), EXPECTED_ID_RST};
        foreach (ids[i]) begin
            set_expected_id(ids[i]);
            send_packet(ids[i], 8'd1, 8'h00, -1, 1'b0, -1);
            send_packet(ids[i], 8'd4, 8'h00, 8'h00, 1'b0, -1);
            send_packet(~ids[i], 8'd4, 8'h00, -1, 1'b0, -1);
            repeat (2) send_random_packet();
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        holdoff_req = HOLDOFF_CYCLES;
        send_packet(id_reg, 8'd24, 8'h00, -1, 1'b0, -1);
        wait_idle();
        send_packet(id_reg, 8'd6, 8'h20, -1, 1'b0, -1);
        wait_idle();
    endtask

    task automatic test_long_packet();
        send_packet(id_reg, 8'd255, 8'h00, -1, 1'b0, -1);
        wait_idle();
    endtask

    task automatic test_random();
        int first_word;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                send_noise($urandom_range(1, 6));
            end else begin
                send_random_packet();
            end
        end
        wait_idle();
    endtask

    task automatic test_steady_stream();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (6) send_random_packet();
        wait_idle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 8'h00;
        i_in_valid   = 1'b0;
        i_rx_byte    = 8'h00;
        errors       = 0;
        words_sent   = 0;
        holdoff_req  = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        id_reg       = EXPECTED_ID_RST;
        ph           = PH_HUNT;
        sync_seen    = 1'b0;
        len_seen     = 8'h00;
        stat_seen    = 8'h00;
        sum_acc      = 8'h00;
        params_left  = 8'h00;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_id_settings();
        test_backpressure();
        test_long_packet();
        test_random();
        test_steady_stream();
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== servo_status_packet_parser.f =====
+incdir+design
design/sspp_pkg.sv
design/sspp_core.sv
design/sspp_out_buf.sv
design/servo_status_packet_parser.sv
design/sspp_checker.sv
tb/tb_top.sv
